FILE: design/stl_pkg.sv
// shared types, character codes and classifier functions for the script token lexer
`default_nettype none

package stl_pkg;

  // kinds of token on the result stream
  typedef enum logic [3:0] {
    K_CHAR   = 4'd0,
    K_EQ     = 4'd1,
    K_LE     = 4'd2,
    K_GE     = 4'd3,
    K_NE     = 4'd4,
    K_CONCAT = 4'd5,
    K_DOTS   = 4'd6,
    K_NUMBER = 4'd7,
    K_NAME   = 4'd8,
    K_STRING = 4'd9,
    K_END    = 4'd10,
    K_ERROR  = 4'd11
  } token_kind_e;

  localparam int unsigned LineOutBits = 16;

  // one result item
  typedef struct packed {
    logic                   last;
    logic [LineOutBits-1:0] line;
    logic [7:0]             chr;
    token_kind_e            kind;
  } result_t;

  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChLbrk   = 8'h5B;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChTilde  = 8'h7E;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChUpperE = 8'h45;
  localparam logic [7:0] ChLowerE = 8'h65;

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == ChUscore);
  endfunction

  // blank, tab, vertical tab, form feed
  function automatic logic is_space(input logic [7:0] c);
    return (c inside {8'h20, 8'h09, 8'h0B, 8'h0C});
  endfunction

endpackage

`default_nettype wire

FILE: design/script_token_lexer.sv
// top level of the script token lexer: byte-serial tokenizer with a result queue
`default_nettype none

// Byte-serial tokenizer for a small scripting language. Each input item is one source
// byte (tdata) or an end-of-input mark (tuser). The block recognizes == <= >= ~=, the
// dot forms . .. ..., numerals, names, a string-start token for a quote or a long
// bracket, single-character tokens, an error token for a malformed long bracket, and
// end of stream; it skips whitespace and -- comments and counts lines (a CR LF or LF CR
// pair is one line, the count saturates). An item yields zero, one or two tokens; the
// last token of an item carries tlast. Timing: the lexer state steps once for each taken
// item, from the registered state through one level of decode to the state registers.
// Tokens go into a four-entry result queue that drives the output port directly; the
// input is ready while the queue has room for two tokens, so an item is taken in every
// cycle as long as the downstream side drains one token per cycle. The output port
// moves at most one token per cycle, so items that give two tokens are paced by it.
module script_token_lexer
  import stl_pkg::*;
#(
  parameter int unsigned LINE_BITS  = 16,
  parameter int unsigned LEVEL_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input item stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  wire logic [0:0]  s_axis_tuser,   // [0] end_of_input
  // token stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [3:0] token_kind, [11:4] char_code,
                                           // [27:12] line_number, [31:28] zero
  output logic             m_axis_tlast    // last_of_run
);

  // lexer modes
  typedef enum logic [3:0] {
    M_IDLE, M_NL_CR, M_NL_LF, M_MINUS, M_COMMENT, M_BRACKET, M_EQ, M_LT,
    M_GT, M_TILDE, M_DOT1, M_DOT2, M_NUM_INT, M_NUM_EXP, M_NUM_TAIL, M_NAME
  } lex_mode_e;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [LINE_BITS-1:0]  LineMax  = {LINE_BITS{1'b1}};
  localparam logic [LEVEL_BITS-1:0] LevelMax = {LEVEL_BITS{1'b1}};

  lex_mode_e             mode_q, mode_d;
  logic [LEVEL_BITS-1:0] level_q, level_d;
  logic [LINE_BITS-1:0]  line_q, line_d;

  logic       in_fire;
  logic [7:0] c;
  logic       eoi;

  // held-back token of the current mode
  logic        fl_valid;
  token_kind_e fl_kind;
  logic [7:0]  fl_chr;

  // continuation of the current mode with this byte
  logic        ab_ok;
  lex_mode_e   ab_mode;
  logic [LEVEL_BITS-1:0] ab_level;
  logic        ab_emit;
  token_kind_e ab_kind;

  // fresh start from idle with this byte
  lex_mode_e   st_mode;
  logic        st_nl;
  logic        st_emit;
  token_kind_e st_kind;
  logic [7:0]  st_chr;

  // tokens of this item
  logic [1:0]  n_res;
  result_t     res0, res1;
  logic [LINE_BITS+LineOutBits-1:0] line_wide;

  // result queue, head always at entry zero
  result_t           q_q [QDepth];
  result_t           q_d [QDepth];
  logic [QCntW-1:0]  cnt_q, cnt_d, cnt_ap;
  logic              pop;

  assign c       = s_axis_tdata;
  assign eoi     = s_axis_tuser[0];
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // room for two tokens decides readiness
  assign s_axis_tready = (cnt_q <= QCntW'(QDepth - 2));
  assign m_axis_tvalid = (cnt_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {4'b0, q_q[0].line, q_q[0].chr, q_q[0].kind};
  assign m_axis_tlast  = q_q[0].last;

  // flush: what the current mode still owes
  always_comb begin
    fl_valid = 1'b1;
    fl_kind  = K_CHAR;
    fl_chr   = '0;
    case (mode_q)
      M_MINUS:   fl_chr = ChMinus;
      M_BRACKET: begin
        if (level_q == '0) begin
          fl_chr = ChLbrk;
        end else begin
          fl_kind = K_ERROR;
        end
      end
      M_EQ:      fl_chr = ChEq;
      M_LT:      fl_chr = ChLt;
      M_GT:      fl_chr = ChGt;
      M_TILDE:   fl_chr = ChTilde;
      M_DOT1:    fl_chr = ChDot;
      M_DOT2:    fl_kind = K_CONCAT;
      M_NUM_INT, M_NUM_EXP, M_NUM_TAIL: fl_kind = K_NUMBER;
      M_NAME:    fl_kind = K_NAME;
      default:   fl_valid = 1'b0;
    endcase
  end

  // absorb: does the byte continue the current token or skip
  always_comb begin
    ab_ok    = 1'b0;
    ab_mode  = mode_q;
    ab_level = level_q;
    ab_emit  = 1'b0;
    ab_kind  = K_CHAR;
    case (mode_q)
      M_NL_CR: begin
        ab_ok   = (c == ChLf);
        ab_mode = M_IDLE;
      end
      M_NL_LF: begin
        ab_ok   = (c == ChCr);
        ab_mode = M_IDLE;
      end
      M_MINUS: begin
        if (c == ChMinus) begin
          ab_ok   = 1'b1;
          ab_mode = M_COMMENT;
        end
      end
      M_COMMENT: ab_ok = !(c == ChLf || c == ChCr);
      M_BRACKET: begin
        if (c == ChEq) begin
          ab_ok = 1'b1;
          if (level_q != LevelMax) begin
            ab_level = level_q + 1'b1;
          end
        end else if (c == ChLbrk) begin
          ab_ok    = 1'b1;
          ab_emit  = 1'b1;
          ab_kind  = K_STRING;
          ab_mode  = M_IDLE;
          ab_level = '0;
        end
      end
      M_EQ, M_LT, M_GT, M_TILDE: begin
        if (c == ChEq) begin
          ab_ok   = 1'b1;
          ab_emit = 1'b1;
          ab_mode = M_IDLE;
          case (mode_q)
            M_EQ:    ab_kind = K_EQ;
            M_LT:    ab_kind = K_LE;
            M_GT:    ab_kind = K_GE;
            default: ab_kind = K_NE;
          endcase
        end
      end
      M_DOT1: begin
        if (c == ChDot) begin
          ab_ok   = 1'b1;
          ab_mode = M_DOT2;
        end else if (is_digit(c)) begin
          ab_ok   = 1'b1;
          ab_mode = M_NUM_INT;
        end
      end
      M_DOT2: begin
        if (c == ChDot) begin
          ab_ok   = 1'b1;
          ab_emit = 1'b1;
          ab_kind = K_DOTS;
          ab_mode = M_IDLE;
        end
      end
      M_NUM_INT: begin
        if (is_digit(c) || c == ChDot) begin
          ab_ok = 1'b1;
        end else if (c == ChUpperE || c == ChLowerE) begin
          ab_ok   = 1'b1;
          ab_mode = M_NUM_EXP;
        end else if (is_word(c)) begin
          ab_ok   = 1'b1;
          ab_mode = M_NUM_TAIL;
        end
      end
      M_NUM_EXP: begin
        if (c == ChPlus || c == ChMinus || is_word(c)) begin
          ab_ok   = 1'b1;
          ab_mode = M_NUM_TAIL;
        end
      end
      M_NUM_TAIL, M_NAME: ab_ok = is_word(c);
      default: ab_ok = 1'b0;
    endcase
  end

  // start: classify the byte from idle
  always_comb begin
    st_mode = M_IDLE;
    st_nl   = 1'b0;
    st_emit = 1'b0;
    st_kind = K_CHAR;
    st_chr  = '0;
    if (c == ChLf) begin
      st_nl   = 1'b1;
      st_mode = M_NL_LF;
    end else if (c == ChCr) begin
      st_nl   = 1'b1;
      st_mode = M_NL_CR;
    end else if (c == ChMinus) begin
      st_mode = M_MINUS;
    end else if (c == ChLbrk) begin
      st_mode = M_BRACKET;
    end else if (c == ChEq) begin
      st_mode = M_EQ;
    end else if (c == ChLt) begin
      st_mode = M_LT;
    end else if (c == ChGt) begin
      st_mode = M_GT;
    end else if (c == ChTilde) begin
      st_mode = M_TILDE;
    end else if (c == ChDquote || c == ChSquote) begin
      st_emit = 1'b1;
      st_kind = K_STRING;
    end else if (c == ChDot) begin
      st_mode = M_DOT1;
    end else if (is_digit(c)) begin
      st_mode = M_NUM_INT;
    end else if (is_alpha(c) || c == ChUscore) begin
      st_mode = M_NAME;
    end else if (!is_space(c)) begin
      st_emit = 1'b1;
      st_chr  = c;
    end
  end

  // combine into next state and up to two tokens; all tokens carry the old line count
  always_comb begin
    mode_d    = mode_q;
    level_d   = level_q;
    line_d    = line_q;
    n_res     = 2'd0;
    line_wide = {{LineOutBits{1'b0}}, line_q};
    res0      = '{last: 1'b0, line: line_wide[LineOutBits-1:0], chr: '0, kind: K_CHAR};
    res1      = res0;
    if (in_fire) begin
      if (eoi) begin
        mode_d  = M_IDLE;
        level_d = '0;
        if (fl_valid) begin
          res0.kind = fl_kind;
          res0.chr  = fl_chr;
          res1.kind = K_END;
          res1.last = 1'b1;
          n_res     = 2'd2;
        end else begin
          res0.kind = K_END;
          res0.last = 1'b1;
          n_res     = 2'd1;
        end
      end else if (ab_ok) begin
        mode_d  = ab_mode;
        level_d = ab_level;
        if (ab_emit) begin
          res0.kind = ab_kind;
          res0.last = 1'b1;
          n_res     = 2'd1;
        end
      end else begin
        mode_d  = st_mode;
        level_d = '0;
        if (st_nl && line_q != LineMax) begin
          line_d = line_q + 1'b1;
        end
        if (fl_valid && st_emit) begin
          res0.kind = fl_kind;
          res0.chr  = fl_chr;
          res1.kind = st_kind;
          res1.chr  = st_chr;
          res1.last = 1'b1;
          n_res     = 2'd2;
        end else if (fl_valid) begin
          res0.kind = fl_kind;
          res0.chr  = fl_chr;
          res0.last = 1'b1;
          n_res     = 2'd1;
        end else if (st_emit) begin
          res0.kind = st_kind;
          res0.chr  = st_chr;
          res0.last = 1'b1;
          n_res     = 2'd1;
        end
      end
    end
  end

  // queue update: shift on pop, append new tokens behind what stays
  always_comb begin
    cnt_ap = cnt_q - QCntW'(pop);
    cnt_d  = cnt_ap + QCntW'(n_res);
    for (int i = 0; i < QDepth; i++) begin
      if (pop && i < QDepth - 1) begin
        q_d[i] = q_q[i+1];
      end else begin
        q_d[i] = q_q[i];
      end
      if (n_res != 2'd0 && QCntW'(i) == cnt_ap) begin
        q_d[i] = res0;
      end
      if (n_res == 2'd2 && QCntW'(i) == cnt_ap + 1'b1) begin
        q_d[i] = res1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      level_q <= '0;
      line_q  <= '0;
      cnt_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      level_q <= level_d;
      line_q  <= line_d;
      cnt_q   <= cnt_d;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

endmodule

`default_nettype wire
